@@ hdl/tccb_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccb_pkg
// Shared sizes, command and character codes, cell and request types for the
// text console cell buffer.
// ----------------------------------------------------------------------------
package tccb_pkg;

  localparam int VISIBLE_ROWS    = 30;
  localparam int VISIBLE_COLUMNS = 80;
  localparam int TOTAL_ROWS      = 32;
  localparam int TOTAL_COLUMNS   = 80;

  // visible window never exceeds the stored grid
  localparam int VROWS = (VISIBLE_ROWS < TOTAL_ROWS) ? VISIBLE_ROWS : TOTAL_ROWS;
  localparam int VCOLS = (VISIBLE_COLUMNS < TOTAL_COLUMNS) ? VISIBLE_COLUMNS : TOTAL_COLUMNS;

  localparam int CELLS  = TOTAL_ROWS * TOTAL_COLUMNS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int ROW_W  = 5;
  localparam int COL_W  = 7;
  localparam int CELL_W = 17;
  localparam int TAB_STEP = 4;

  localparam logic [ROW_W-1:0] VROWS_M1 = ROW_W'(VROWS - 1);
  localparam logic [COL_W-1:0] VCOLS_M1 = COL_W'(VCOLS - 1);
  localparam logic [ROW_W-1:0] TROWS_M1 = ROW_W'(TOTAL_ROWS - 1);
  localparam logic [COL_W-1:0] TCOLS_M1 = COL_W'(TOTAL_COLUMNS - 1);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CELLS - 1);

  localparam logic [2:0] CMD_PRINT       = 3'd0;
  localparam logic [2:0] CMD_SET_CURSOR  = 3'd1;
  localparam logic [2:0] CMD_BLINK       = 3'd2;
  localparam logic [2:0] CMD_CLEAR       = 3'd3;
  localparam logic [2:0] CMD_SCROLL_UP   = 3'd4;
  localparam logic [2:0] CMD_SCROLL_DOWN = 3'd5;
  localparam logic [2:0] CMD_READ        = 3'd6;

  localparam logic [7:0] CHR_BS        = 8'h08;
  localparam logic [7:0] CHR_TAB       = 8'h09;
  localparam logic [7:0] CHR_LF        = 8'h0A;
  localparam logic [7:0] CHR_CR        = 8'h0D;
  localparam logic [7:0] CHR_CTRL_MAX  = 8'h1F;
  localparam logic [7:0] CHR_SPACE     = 8'h20;
  localparam logic [7:0] CHR_PRINT_MAX = 8'h7F;

  typedef logic [ADDR_W-1:0] addr_t;

  typedef struct packed {
    logic [7:0] ch;
    logic [3:0] fg;
    logic [3:0] bg;
    logic       inv;
  } cell_t;

  localparam cell_t BLANK_CELL = '{ch: CHR_SPACE, fg: 4'd0, bg: 4'd0, inv: 1'b0};

  typedef struct packed {
    logic  rd_en;
    addr_t rd_addr;
    logic  wr_en;
    addr_t wr_addr;
    cell_t wr_data;
  } mem_req_t;

  typedef struct packed {
    logic [ROW_W-1:0] cursor_row;
    logic [COL_W-1:0] cursor_col;
    cell_t            rd_cell;
  } result_t;

  function automatic addr_t cell_addr(logic [ROW_W-1:0] r, logic [COL_W-1:0] c);
    return addr_t'(r) * addr_t'(TOTAL_COLUMNS) + addr_t'(c);
  endfunction

endpackage

@@ hdl/tccb_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccb_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read.
// ----------------------------------------------------------------------------
module tccb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ hdl/tccb_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccb_ctrl
// Command sequencer: cursor and blink state, single-cell read-modify-write,
// clear and scroll sweeps over the cell memory, clearing pass after reset.
// ----------------------------------------------------------------------------
module tccb_ctrl import tccb_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cursor_enable,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [2:0]       command,
  input  logic [7:0]       char_code,
  input  logic [3:0]       fg_index,
  input  logic [3:0]       bg_index,
  input  logic [ROW_W-1:0] row,
  input  logic [COL_W-1:0] column,
  output mem_req_t         mem_req,
  input  cell_t            rd_data,
  output logic             res_valid,
  input  logic             res_ready,
  output result_t          res
);

  localparam logic [2:0] S_INIT     = 3'd0;
  localparam logic [2:0] S_IDLE     = 3'd1;
  localparam logic [2:0] S_DISPATCH = 3'd2;
  localparam logic [2:0] S_RMW      = 3'd3;
  localparam logic [2:0] S_READ     = 3'd4;
  localparam logic [2:0] S_SWEEP    = 3'd5;
  localparam logic [2:0] S_TAIL     = 3'd6;
  localparam logic [2:0] S_DONE     = 3'd7;

  logic [2:0]       state;
  logic [2:0]       cmd;
  logic [7:0]       chr;
  logic [3:0]       fg;
  logic [3:0]       bg;
  logic [ROW_W-1:0] row_q;
  logic [COL_W-1:0] col_q;
  logic [ROW_W-1:0] cur_row;
  logic [COL_W-1:0] cur_col;
  logic             phase;
  addr_t            init_addr;
  logic [ROW_W-1:0] sw_row;
  logic [COL_W-1:0] sw_col;
  logic             sw_copy;
  logic             sw_up;
  logic             pend_valid;
  addr_t            pend_addr;
  logic             pend_blank;
  cell_t            cell_q;

  addr_t            cur_addr;
  addr_t            sw_addr;
  addr_t            src_addr;
  addr_t            rd_cell_addr;
  logic [ROW_W-1:0] src_row;
  logic [ROW_W-1:0] end_row;
  logic             sw_blank;
  logic             sw_last;
  logic             printable;
  logic [COL_W:0]   col_inc;
  logic [ROW_W:0]   row_inc;
  logic [COL_W:0]   col_tab;
  logic [ROW_W-1:0] rd_row_sat;
  logic [COL_W-1:0] rd_col_sat;
  cell_t            pend_data;
  cell_t            rmw_data;

  assign printable = (chr > CHR_CTRL_MAX) && (chr <= CHR_PRINT_MAX);
  assign cur_addr  = cell_addr(cur_row, cur_col);
  assign col_inc   = {1'b0, cur_col} + (COL_W + 1)'(1);
  assign row_inc   = {1'b0, cur_row} + (ROW_W + 1)'(1);
  assign col_tab   = {1'b0, cur_col} + (COL_W + 1)'(TAB_STEP);

  assign rd_row_sat   = ({1'b0, row_q} < (ROW_W + 1)'(TOTAL_ROWS)) ? row_q : TROWS_M1;
  assign rd_col_sat   = ({1'b0, col_q} < (COL_W + 1)'(TOTAL_COLUMNS)) ? col_q : TCOLS_M1;
  assign rd_cell_addr = cell_addr(rd_row_sat, rd_col_sat);

  // sweep walks destination cells; the far row takes a blanked copy of itself
  assign end_row  = sw_up ? VROWS_M1 : '0;
  assign sw_blank = (sw_row == end_row);
  assign sw_last  = sw_blank && (sw_col == VCOLS_M1);
  assign src_row  = sw_blank ? sw_row
                  : (sw_up ? sw_row + ROW_W'(1) : sw_row - ROW_W'(1));
  assign sw_addr  = cell_addr(sw_row, sw_col);
  assign src_addr = cell_addr(src_row, sw_col);

  always_comb begin
    pend_data = rd_data;
    if (pend_blank) begin
      pend_data.ch = CHR_SPACE;
    end
    rmw_data     = rd_data;
    rmw_data.inv = (cmd == CMD_BLINK) ? phase : 1'b0;
  end

  always_comb begin
    mem_req = '0;
    case (state)
      S_INIT: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = init_addr;
        mem_req.wr_data = BLANK_CELL;
      end
      S_DISPATCH: begin
        case (cmd)
          CMD_PRINT: begin
            if (printable) begin
              mem_req.wr_en   = 1'b1;
              mem_req.wr_addr = cur_addr;
              mem_req.wr_data = '{ch: chr, fg: fg, bg: bg, inv: 1'b0};
            end else begin
              mem_req.rd_en   = 1'b1;
              mem_req.rd_addr = cur_addr;
            end
          end
          CMD_BLINK: begin
            mem_req.rd_en   = cursor_enable;
            mem_req.rd_addr = cur_addr;
          end
          CMD_READ: begin
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = rd_cell_addr;
          end
          default: begin
          end
        endcase
      end
      S_RMW: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = cur_addr;
        mem_req.wr_data = rmw_data;
      end
      S_SWEEP: begin
        if (sw_copy) begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = src_addr;
          mem_req.wr_en   = pend_valid;
          mem_req.wr_addr = pend_addr;
          mem_req.wr_data = pend_data;
        end else begin
          mem_req.wr_en   = 1'b1;
          mem_req.wr_addr = sw_addr;
          mem_req.wr_data = '{ch: CHR_SPACE, fg: fg, bg: bg, inv: 1'b0};
        end
      end
      S_TAIL: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = pend_addr;
        mem_req.wr_data = pend_data;
      end
      default: begin
      end
    endcase
  end

  assign in_ready        = (state == S_IDLE);
  assign res_valid       = (state == S_DONE);
  assign res.cursor_row  = cur_row;
  assign res.cursor_col  = cur_col;
  assign res.rd_cell     = cell_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_INIT;
      init_addr  <= '0;
      cur_row    <= '0;
      cur_col    <= '0;
      phase      <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      case (state)
        S_INIT: begin
          init_addr <= init_addr + ADDR_W'(1);
          if (init_addr == LAST_ADDR) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            cmd    <= command;
            chr    <= char_code;
            fg     <= fg_index;
            bg     <= bg_index;
            row_q  <= row;
            col_q  <= column;
            cell_q <= '0;
            state  <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          sw_col     <= '0;
          pend_valid <= 1'b0;
          state      <= S_DONE;
          case (cmd)
            CMD_PRINT: begin
              if (printable) begin
                // advance, wrap at the right edge, scroll below the last row
                if (col_inc >= (COL_W + 1)'(VCOLS)) begin
                  cur_col <= '0;
                  if (row_inc >= (ROW_W + 1)'(VROWS)) begin
                    cur_row <= VROWS_M1;
                    sw_row  <= '0;
                    sw_up   <= 1'b1;
                    sw_copy <= 1'b1;
                    state   <= S_SWEEP;
                  end else begin
                    cur_row <= row_inc[ROW_W-1:0];
                  end
                end else begin
                  cur_col <= col_inc[COL_W-1:0];
                end
              end else begin
                state <= S_RMW;
              end
            end
            CMD_SET_CURSOR: begin
              cur_row <= ({1'b0, row_q} < (ROW_W + 1)'(VROWS)) ? row_q : VROWS_M1;
              cur_col <= ({1'b0, col_q} < (COL_W + 1)'(VCOLS)) ? col_q : VCOLS_M1;
            end
            CMD_BLINK: begin
              if (cursor_enable) begin
                phase <= ~phase;
                state <= S_RMW;
              end
            end
            CMD_CLEAR: begin
              cur_row <= '0;
              cur_col <= '0;
              phase   <= 1'b0;
              sw_row  <= '0;
              sw_up   <= 1'b1;
              sw_copy <= 1'b0;
              state   <= S_SWEEP;
            end
            CMD_SCROLL_UP: begin
              sw_row  <= '0;
              sw_up   <= 1'b1;
              sw_copy <= 1'b1;
              state   <= S_SWEEP;
            end
            CMD_SCROLL_DOWN: begin
              sw_row  <= VROWS_M1;
              sw_up   <= 1'b0;
              sw_copy <= 1'b1;
              state   <= S_SWEEP;
            end
            CMD_READ: begin
              state <= S_READ;
            end
            default: begin
            end
          endcase
        end
        S_RMW: begin
          state <= S_DONE;
          if (cmd == CMD_PRINT) begin
            case (chr)
              CHR_CR: begin
                cur_col <= '0;
              end
              CHR_LF: begin
                if (row_inc < (ROW_W + 1)'(VROWS)) begin
                  cur_row <= row_inc[ROW_W-1:0];
                end else begin
                  sw_row  <= '0;
                  sw_up   <= 1'b1;
                  sw_copy <= 1'b1;
                  state   <= S_SWEEP;
                end
              end
              CHR_TAB: begin
                cur_col <= (col_tab <= (COL_W + 1)'(VCOLS - 1)) ? col_tab[COL_W-1:0]
                                                                 : VCOLS_M1;
              end
              CHR_BS: begin
                if (cur_col != '0) begin
                  cur_col <= cur_col - COL_W'(1);
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_READ: begin
          cell_q <= rd_data;
          state  <= S_DONE;
        end
        S_SWEEP: begin
          pend_valid <= sw_copy;
          pend_addr  <= sw_addr;
          pend_blank <= sw_blank;
          if (sw_col == VCOLS_M1) begin
            sw_col <= '0;
            sw_row <= sw_up ? sw_row + ROW_W'(1) : sw_row - ROW_W'(1);
          end else begin
            sw_col <= sw_col + COL_W'(1);
          end
          if (sw_last) begin
            state <= sw_copy ? S_TAIL : S_DONE;
          end
        end
        S_TAIL: begin
          pend_valid <= 1'b0;
          state      <= S_DONE;
        end
        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ hdl/text_console_cell_buffer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_cell_buffer
// Character cell grid with cursor, blink, clear, scroll and cell read-back.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one command word: command,
//   char_code, fg_index, bg_index, row, column. Output channel
//   (out_valid/out_ready) returns exactly one result word per command: the
//   cursor after the command and, for read cell, the addressed cell (zero
//   otherwise). cfg_we/cfg_data write cursor_enable; write it only while idle.
//   Commands are taken one at a time. Print of a character writes its cell
//   directly; other bytes and enabled blink ticks read and rewrite the
//   cursor cell, and read cell reads the addressed cell. Clear and a scroll
//   sweep the VROWS*VCOLS (2400) visible cells through the single write port
//   of the cell memory. A print that wraps off the last row scrolls up, and
//   so does a line feed on the last row. After reset the cell memory is
//   cleared to spaces, one cell a cycle, over all TOTAL_ROWS*TOTAL_COLUMNS
//   (2560) cells; in_ready stays low meanwhile.
//   The result sits in an output register, so a stalled receiver holds the
//   current word there while the next command is accepted and processed; that
//   command then waits for the register to drain before its result is loaded.
// ----------------------------------------------------------------------------
module text_console_cell_buffer import tccb_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic             cfg_data,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [2:0]       command,
  input  logic [7:0]       char_code,
  input  logic [3:0]       fg_index,
  input  logic [3:0]       bg_index,
  input  logic [ROW_W-1:0] row,
  input  logic [COL_W-1:0] column,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [ROW_W-1:0] cursor_row,
  output logic [COL_W-1:0] cursor_column,
  output logic [7:0]       cell_char,
  output logic [3:0]       cell_fg,
  output logic [3:0]       cell_bg,
  output logic             cell_invert
);

  logic     cursor_enable;
  mem_req_t mem_req;
  cell_t    rd_data;
  logic     res_valid;
  logic     res_ready;
  result_t  res;
  logic     load;

  // configuration register: blink ticks only show the cursor when set
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_enable <= 1'b0;
    end else if (cfg_we) begin
      cursor_enable <= cfg_data;
    end
  end

  tccb_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .cursor_enable (cursor_enable),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .command       (command),
    .char_code     (char_code),
    .fg_index      (fg_index),
    .bg_index      (bg_index),
    .row           (row),
    .column        (column),
    .mem_req       (mem_req),
    .rd_data       (rd_data),
    .res_valid     (res_valid),
    .res_ready     (res_ready),
    .res           (res)
  );

  // one cell per entry, row-major over the whole stored grid
  tccb_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_cells (
    .clk     (clk),
    .wr_en   (mem_req.wr_en),
    .wr_addr (mem_req.wr_addr),
    .wr_data (mem_req.wr_data),
    .rd_en   (mem_req.rd_en),
    .rd_addr (mem_req.rd_addr),
    .rd_data (rd_data)
  );

  // output register: load when empty or being drained this cycle
  assign load      = res_valid && (!out_valid || out_ready);
  assign res_ready = load;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // hold the payload until the next word is loaded
  always_ff @(posedge clk) begin
    if (load) begin
      cursor_row    <= res.cursor_row;
      cursor_column <= res.cursor_col;
      cell_char     <= res.rd_cell.ch;
      cell_fg       <= res.rd_cell.fg;
      cell_bg       <= res.rd_cell.bg;
      cell_invert   <= res.rd_cell.inv;
    end
  end

endmodule

@@ hdl/tccb_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccb_checker
// Port-level checks for the text console cell buffer, bound to the top level.
// ----------------------------------------------------------------------------
module tccb_checker import tccb_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [ROW_W-1:0] cursor_row,
  input logic [COL_W-1:0] cursor_column,
  input logic [7:0]       cell_char,
  input logic [3:0]       cell_fg,
  input logic [3:0]       cell_bg,
  input logic             cell_invert
);

  // reset starts the clearing pass: nothing accepted, nothing shown
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !in_ready && !out_valid)
    else $error("ready or valid right after reset");

  // one command at a time: ready drops after each acceptance
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second command accepted back to back");

  // the reported cursor lies inside the visible window whenever out_valid is high
  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ({1'b0, cursor_row} < (ROW_W + 1)'(VROWS)) &&
                  ({1'b0, cursor_column} < (COL_W + 1)'(VCOLS)))
    else $error("cursor outside visible window");

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(cursor_row) &&
      $stable(cursor_column) && $stable(cell_char) && $stable(cell_fg) &&
      $stable(cell_bg) && $stable(cell_invert))
    else $error("result word changed while stalled");

endmodule

bind text_console_cell_buffer tccb_checker u_tccb_checker (.*);
